// File: hw/rtl/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// shared widths, codes and request structs of the potential field motion step
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int COORD_BITS    = 10;
  localparam int POS_W         = COORD_BITS + FRAC_BITS;
  localparam int NUM_OBSTACLES = 16;
  localparam int OBS_IDX_W     = $clog2(NUM_OBSTACLES);
  localparam int NUM_WALLS     = 4;
  localparam int NUM_TERMS     = NUM_OBSTACLES + NUM_WALLS;
  localparam int TERM_W        = $clog2(NUM_TERMS);
  localparam int PUSH_W        = 24;
  localparam int ACC_W         = 32;

  localparam int DIV_NW        = 42;
  localparam int DIV_DW        = 20;
  localparam int DIV_CNT_W     = $clog2(DIV_NW + 1);
  localparam int SQ_RW         = 38;
  localparam int SQ_QW         = SQ_RW / 2;
  localparam int SQ_CNT_W      = $clog2(SQ_QW + 1);

  localparam int ONE           = 1 << FRAC_BITS;
  localparam int DMIN          = (ONE + 9) / 10;
  localparam int DIAG          = (7071 * ONE + 5000) / 10000;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [SQ_RW-1:0] rad;
  } sqrt_req_t;

endpackage

// File: hw/rtl/pfm_div.sv
// ----------------------------------------------------------------------------
// pfm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfm_div import pfm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DW-1:0]    rem_r;
  logic [DIV_NW-1:0]    quo_r;
  logic [DIV_DW-1:0]    den_r;

  logic [DIV_DW:0]      shifted;
  logic [DIV_DW:0]      trial;
  logic                 ge;
  logic [DIV_DW-1:0]    rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_NW-1]};
    trial   = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NW);
        rem_r  <= '0;
        quo_r  <= req.num;
        den_r  <= req.den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hw/rtl/pfm_isqrt.sv
// ----------------------------------------------------------------------------
// pfm_isqrt
// digit-by-digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
module pfm_isqrt import pfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  sqrt_req_t        req,
  output logic             done,
  output logic [SQ_QW-1:0] root
);

  logic                busy_r;
  logic                done_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [SQ_RW-1:0]    rad_r;
  logic [SQ_QW+1:0]    rem_r;
  logic [SQ_QW-1:0]    root_r;

  logic [SQ_QW+3:0]    shifted;
  logic [SQ_QW+3:0]    trial;
  logic                ge;
  logic [SQ_QW+3:0]    diffv;

  always_comb begin
    shifted = {rem_r, rad_r[SQ_RW-1:SQ_RW-2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = (shifted >= trial);
    diffv   = shifted - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= SQ_CNT_W'(SQ_QW);
        rad_r  <= req.rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? diffv[SQ_QW+1:0] : shifted[SQ_QW+1:0];
        root_r <= {root_r[SQ_QW-2:0], ge};
        rad_r  <= {rad_r[SQ_RW-3:0], 2'b00};
        cnt_r  <= cnt_r - SQ_CNT_W'(1);
        if (cnt_r == SQ_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hw/rtl/potential_field_motion_step.sv
// ----------------------------------------------------------------------------
// potential_field_motion_step
// drone position update from commanded direction and wall/obstacle repulsion
// ----------------------------------------------------------------------------
// sequence: write, clear and unknown requests finish in the idle state; a tick
//   that leaves the drone unstarted goes straight to the output state; a moving
//   tick divides for the inverse radius, then takes each wall and occupied slot
//   in turn, with the shared divider and root unit
// throughput: one request at a time, next request taken when the sequencer idles
// reset: synchronous active low; position to field centre, obstacle table cleared
// ----------------------------------------------------------------------------
module potential_field_motion_step import pfm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [17:0]              cfg_wdata,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_req_type,
  input  logic signed [15:0]       in_command_x,
  input  logic signed [15:0]       in_command_y,
  input  logic [3:0]               in_entry_index,
  input  logic [9:0]               in_entry_x,
  input  logic [9:0]               in_entry_y,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [17:0]              out_position_x_out,
  output logic [17:0]              out_position_y_out,
  output logic signed [23:0]       out_push_x,
  output logic signed [23:0]       out_push_y,
  output logic                     out_moving
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INVR   = 5'd1;
  localparam logic [4:0] S_INVR_W = 5'd2;
  localparam logic [4:0] S_TERM   = 5'd3;
  localparam logic [4:0] S_SQX    = 5'd4;
  localparam logic [4:0] S_SQY    = 5'd5;
  localparam logic [4:0] S_SQRT   = 5'd6;
  localparam logic [4:0] S_SQRT_W = 5'd7;
  localparam logic [4:0] S_CHK    = 5'd8;
  localparam logic [4:0] S_INVD_W = 5'd9;
  localparam logic [4:0] S_DIFF   = 5'd10;
  localparam logic [4:0] S_GAIN   = 5'd11;
  localparam logic [4:0] S_MAG    = 5'd12;
  localparam logic [4:0] S_TX_D   = 5'd13;
  localparam logic [4:0] S_TX_W   = 5'd14;
  localparam logic [4:0] S_TY_D   = 5'd15;
  localparam logic [4:0] S_TY_W   = 5'd16;
  localparam logic [4:0] S_MVX    = 5'd17;
  localparam logic [4:0] S_MVX_W  = 5'd18;
  localparam logic [4:0] S_MVY    = 5'd19;
  localparam logic [4:0] S_MVY_W  = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;

  localparam logic [DIV_NW-1:0] INV_NUM = DIV_NW'(1) << (2 * FRAC_BITS);
  // x/100 as (x * ceil(2^30/100)) >> 30, exact over the whole move range
  localparam logic [23:0]       RECIP_100 = 24'd10737419;

  logic [4:0]                state_r, state_nxt;
  logic [TERM_W-1:0]         t_r;
  logic                      started_r;
  logic [POS_W-1:0]          drone_x_r, drone_y_r;
  logic [COORD_BITS-1:0]     obs_x_r [NUM_OBSTACLES];
  logic [COORD_BITS-1:0]     obs_y_r [NUM_OBSTACLES];
  logic [15:0]               gain_r;
  logic [17:0]               rho_r;
  logic [9:0]                wid_r, hgt_r;
  logic signed [9:0]         dirx_r, diry_r;
  logic [16:0]               inv_rho_r, inv_d_r;
  logic [DIV_DW-1:0]         d_r;
  logic [17:0]               ax_r, ay_r;
  logic                      negx_r, negy_r;
  logic [SQ_RW-1:0]          sumsq_r;
  logic [47:0]               prod_r;
  logic [22:0]               mag_r;
  logic signed [ACC_W-1:0]   accx_r, accy_r;
  logic signed [PUSH_W-1:0]  px_r, py_r;
  logic                      mneg_r;

  logic                      out_valid_r;
  logic [17:0]               out_px_r, out_py_r;
  logic signed [23:0]        out_pushx_r, out_pushy_r;
  logic                      out_moving_r;

  div_req_t                  div_req;
  logic                      div_done;
  logic [DIV_NW-1:0]         div_quo;
  sqrt_req_t                 sq_req;
  logic                      sq_done;
  logic [SQ_QW-1:0]          sq_root;

  logic                      accept;
  logic                      last_term;
  logic [TERM_W-1:0]         t_m4;
  logic [OBS_IDX_W-1:0]      obs_i;
  logic [COORD_BITS-1:0]     cur_ox, cur_oy;
  logic [9:0]                w_eff, h_eff;
  logic signed [19:0]        wall_d;
  logic [DIV_DW-1:0]         wall_df;
  logic signed [19:0]        dx, dy;
  logic [16:0]               diff;
  logic [22:0]               mag_c;
  logic signed [ACC_W-1:0]   mag_ext, q_ext;
  logic [23:0]               mul_a, mul_b;
  logic                      mul_en;
  logic signed [ACC_W-1:0]   acc_sel;
  logic signed [9:0]         dir_sel;
  logic signed [PUSH_W-1:0]  psat;
  logic signed [25:0]        mvnum;
  logic [25:0]               mvabs;
  logic signed [21:0]        mstep;
  logic [POS_W-1:0]          newpos;
  logic                      can_load;
  logic                      start_now;
  logic signed [1:0]         sgx, sgy;
  logic signed [9:0]         dxn, dyn;

  function automatic logic signed [1:0] dir_of(input logic signed [15:0] c);
    logic signed [19:0] c10;
    c10 = ({{4{c[15]}}, c} <<< 3) + ({{4{c[15]}}, c} <<< 1);
    if (c10 > 20'sd256) begin
      return 2'sd1;
    end else if (c10 < -20'sd256) begin
      return -2'sd1;
    end
    return 2'sd0;
  endfunction

  function automatic logic signed [PUSH_W-1:0] sat_push(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(8388607)) begin
      return 24'sh7FFFFF;
    end else if (v < -ACC_W'(8388608)) begin
      return 24'sh800000;
    end
    return v[PUSH_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [21:0] p,
                                                 input logic [9:0] dim);
    logic [9:0]        dm1;
    logic signed [21:0] hi;
    dm1 = dim - 10'd1;
    hi  = {4'b0000, dm1, 8'h00};
    if (p < 22'sd256) begin
      return POS_W'(ONE);
    end else if (p > hi) begin
      return hi[POS_W-1:0];
    end
    return p[POS_W-1:0];
  endfunction

  pfm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  pfm_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    last_term = (t_r == TERM_W'(NUM_TERMS - 1));
    t_m4      = t_r - TERM_W'(NUM_WALLS);
    obs_i     = t_m4[OBS_IDX_W-1:0];
    cur_ox    = obs_x_r[obs_i];
    cur_oy    = obs_y_r[obs_i];
    w_eff     = (wid_r < 10'd2) ? 10'd2 : wid_r;
    h_eff     = (hgt_r < 10'd2) ? 10'd2 : hgt_r;

    case (t_r[1:0])
      2'd0:    wall_d = {2'b00, drone_x_r};
      2'd1:    wall_d = {2'b00, w_eff, 8'h00} - {2'b00, drone_x_r};
      2'd2:    wall_d = {2'b00, drone_y_r};
      default: wall_d = {2'b00, h_eff, 8'h00} - {2'b00, drone_y_r};
    endcase
    wall_df = (wall_d < 20'sd26) ? DIV_DW'(DMIN) : wall_d;

    dx = {2'b00, drone_x_r} - {2'b00, cur_ox, 8'h00};
    dy = {2'b00, drone_y_r} - {2'b00, cur_oy, 8'h00};

    diff    = inv_d_r - inv_rho_r;
    mag_c   = prod_r[30:8];
    mag_ext = {9'b0, mag_c};
    q_ext   = {9'b0, div_quo[22:0]};

    acc_sel = (state_r == S_MVX) ? accx_r : accy_r;
    dir_sel = (state_r == S_MVX) ? dirx_r : diry_r;
    psat    = sat_push(acc_sel);
    mvnum   = ({{16{dir_sel[9]}}, dir_sel} <<< 3) + ({{16{dir_sel[9]}}, dir_sel} <<< 1)
            + {{2{psat[23]}}, psat} + 26'sd50;
    mvabs   = mvnum[25] ? (26'd99 - mvnum) : mvnum;
    mstep   = mneg_r ? -$signed({4'b0000, prod_r[47:30]}) : $signed({4'b0000, prod_r[47:30]});
    newpos  = (state_r == S_MVX_W) ?
              clamp_pos({4'b0000, drone_x_r} + mstep, w_eff) :
              clamp_pos({4'b0000, drone_y_r} + mstep, h_eff);

    sgx       = dir_of(in_command_x);
    sgy       = dir_of(in_command_y);
    start_now = started_r || (sgx != 2'sd0) || (sgy != 2'sd0);
    if (sgx != 2'sd0 && sgy != 2'sd0) begin
      dxn = (sgx > 2'sd0) ? 10'(DIAG) : -10'(DIAG);
      dyn = (sgy > 2'sd0) ? 10'(DIAG) : -10'(DIAG);
    end else begin
      dxn = (sgx > 2'sd0) ? 10'(ONE) : ((sgx < 2'sd0) ? -10'(ONE) : 10'sd0);
      dyn = (sgy > 2'sd0) ? 10'(ONE) : ((sgy < 2'sd0) ? -10'(ONE) : 10'sd0);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_SQX: begin
        mul_a = {6'b0, ax_r};
        mul_b = {6'b0, ax_r};
      end
      S_SQY: begin
        mul_a = {6'b0, ay_r};
        mul_b = {6'b0, ay_r};
      end
      S_DIFF: begin
        mul_a = {7'b0, diff};
        mul_b = {7'b0, diff};
      end
      S_GAIN: begin
        mul_a = {8'b0, gain_r};
        mul_b = {9'b0, prod_r[22:8]};
      end
      S_MAG: begin
        mul_a = {1'b0, mag_c};
        mul_b = {6'b0, ax_r};
      end
      S_TX_W: begin
        mul_a = {1'b0, mag_r};
        mul_b = {6'b0, ay_r};
      end
      S_MVX, S_MVY: begin
        mul_a = mvabs[23:0];
        mul_b = RECIP_100;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_req = '0;
    sq_req  = '0;
    case (state_r)
      S_INVR: begin
        div_req.start = 1'b1;
        div_req.num   = INV_NUM;
        div_req.den   = {2'b00, rho_r};
      end
      S_CHK: begin
        div_req.start = (d_r < {2'b00, rho_r});
        div_req.num   = INV_NUM;
        div_req.den   = d_r;
      end
      S_TX_D, S_TY_D: begin
        div_req.start = 1'b1;
        div_req.num   = prod_r[DIV_NW-1:0];
        div_req.den   = d_r;
      end
      S_SQRT: begin
        sq_req.start = 1'b1;
        sq_req.rad   = sumsq_r + prod_r[SQ_RW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_req_type == REQ_TICK) begin
          state_nxt = start_now ? S_INVR : S_OUT;
        end
      end
      S_INVR:   state_nxt = S_INVR_W;
      S_INVR_W: if (div_done) state_nxt = S_TERM;
      S_TERM: begin
        if (t_r < TERM_W'(NUM_WALLS)) begin
          state_nxt = S_CHK;
        end else if (cur_ox == '0) begin
          state_nxt = last_term ? S_MVX : S_TERM;
        end else begin
          state_nxt = S_SQX;
        end
      end
      S_SQX:    state_nxt = S_SQY;
      S_SQY:    state_nxt = S_SQRT;
      S_SQRT:   state_nxt = S_SQRT_W;
      S_SQRT_W: if (sq_done) state_nxt = S_CHK;
      S_CHK: begin
        if (d_r < {2'b00, rho_r}) begin
          state_nxt = S_INVD_W;
        end else begin
          state_nxt = last_term ? S_MVX : S_TERM;
        end
      end
      S_INVD_W: if (div_done) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_GAIN;
      S_GAIN:   state_nxt = S_MAG;
      S_MAG: begin
        if (t_r < TERM_W'(NUM_WALLS)) begin
          state_nxt = last_term ? S_MVX : S_TERM;
        end else begin
          state_nxt = S_TX_D;
        end
      end
      S_TX_D:   state_nxt = S_TX_W;
      S_TX_W:   if (div_done) state_nxt = S_TY_D;
      S_TY_D:   state_nxt = S_TY_W;
      S_TY_W:   if (div_done) state_nxt = last_term ? S_MVX : S_TERM;
      S_MVX:    state_nxt = S_MVX_W;
      S_MVX_W:  state_nxt = S_MVY;
      S_MVY:    state_nxt = S_MVY_W;
      S_MVY_W:  state_nxt = S_OUT;
      S_OUT:    if (can_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      t_r         <= '0;
      started_r   <= 1'b0;
      drone_x_r   <= POS_W'(40 * ONE);
      drone_y_r   <= POS_W'(20 * ONE);
      gain_r      <= 16'd256;
      rho_r       <= 18'd1280;
      wid_r       <= 10'd80;
      hgt_r       <= 10'd40;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_OBSTACLES; i++) begin
        obs_x_r[i] <= '0;
        obs_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN:   gain_r <= cfg_wdata[15:0];
          REG_RADIUS: rho_r  <= cfg_wdata[17:0];
          REG_WIDTH:  wid_r  <= cfg_wdata[9:0];
          REG_HEIGHT: hgt_r  <= cfg_wdata[9:0];
          default: ;
        endcase
      end

      if (mul_en) begin
        prod_r <= mul_a * mul_b;
      end

      if (state_nxt == S_TERM && state_r != S_INVR_W) begin
        t_r <= t_r + TERM_W'(1);
      end

      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_req_type)
              REQ_TICK: begin
                started_r <= start_now;
                dirx_r    <= dxn;
                diry_r    <= dyn;
                accx_r    <= '0;
                accy_r    <= '0;
                px_r      <= '0;
                py_r      <= '0;
                t_r       <= '0;
              end
              REQ_WRITE: begin
                obs_x_r[in_entry_index[OBS_IDX_W-1:0]] <= in_entry_x[COORD_BITS-1:0];
                obs_y_r[in_entry_index[OBS_IDX_W-1:0]] <= in_entry_y[COORD_BITS-1:0];
              end
              REQ_CLEAR: begin
                for (int i = 0; i < NUM_OBSTACLES; i++) begin
                  obs_x_r[i] <= '0;
                  obs_y_r[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_INVR_W: if (div_done) inv_rho_r <= div_quo[16:0];
        S_TERM: begin
          if (t_r < TERM_W'(NUM_WALLS)) begin
            d_r <= wall_df;
          end else begin
            negx_r <= dx[19];
            negy_r <= dy[19];
            ax_r   <= dx[19] ? 18'(-dx) : dx[17:0];
            ay_r   <= dy[19] ? 18'(-dy) : dy[17:0];
          end
        end
        S_SQY: sumsq_r <= prod_r[SQ_RW-1:0];
        S_SQRT_W: begin
          if (sq_done) begin
            d_r <= (sq_root < SQ_QW'(DMIN)) ? DIV_DW'(DMIN) : {1'b0, sq_root};
          end
        end
        S_INVD_W: if (div_done) inv_d_r <= div_quo[16:0];
        S_MAG: begin
          mag_r <= mag_c;
          if (t_r < TERM_W'(NUM_WALLS)) begin
            case (t_r[1:0])
              2'd0:    accx_r <= accx_r + mag_ext;
              2'd1:    accx_r <= accx_r - mag_ext;
              2'd2:    accy_r <= accy_r + mag_ext;
              default: accy_r <= accy_r - mag_ext;
            endcase
          end
        end
        S_TX_W: begin
          if (div_done) begin
            accx_r <= negx_r ? accx_r - q_ext : accx_r + q_ext;
          end
        end
        S_TY_W: begin
          if (div_done) begin
            accy_r <= negy_r ? accy_r - q_ext : accy_r + q_ext;
          end
        end
        S_MVX: begin
          px_r   <= psat;
          mneg_r <= mvnum[25];
        end
        S_MVX_W: drone_x_r <= newpos;
        S_MVY: begin
          py_r   <= psat;
          mneg_r <= mvnum[25];
        end
        S_MVY_W: drone_y_r <= newpos;
        S_OUT: begin
          if (can_load) begin
            out_valid_r  <= 1'b1;
            out_px_r     <= drone_x_r;
            out_py_r     <= drone_y_r;
            out_pushx_r  <= px_r;
            out_pushy_r  <= py_r;
            out_moving_r <= started_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position_x_out = out_px_r;
  assign out_position_y_out = out_py_r;
  assign out_push_x         = out_pushx_r;
  assign out_push_y         = out_pushy_r;
  assign out_moving         = out_moving_r;

endmodule

// File: dv/tb_potential_field_motion_step.sv
// ----------------------------------------------------------------------------
// tb_potential_field_motion_step
// drives obstacle writes, clears and ticks through the request channel, holds
// its own fixed point model of the drone and checks every result in order
// ----------------------------------------------------------------------------
module tb_potential_field_motion_step import pfm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int LIMIT_CYCLES = 20000000;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [17:0]        pos_x;
    logic [17:0]        pos_y;
    logic signed [23:0] push_x;
    logic signed [23:0] push_y;
    logic               moving;
  } motion_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] cmd_x;
    logic signed [15:0] cmd_y;
    logic [3:0]         slot;
    logic [9:0]         ox;
    logic [9:0]         oy;
    logic               typed;
    motion_t            want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [17:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic signed [15:0] in_command_x;
  logic signed [15:0] in_command_y;
  logic [3:0] in_entry_index;
  logic [9:0] in_entry_x;
  logic [9:0] in_entry_y;
  logic out_valid;
  logic out_ready;
  logic [17:0] out_position_x_out;
  logic [17:0] out_position_y_out;
  logic signed [23:0] out_push_x;
  logic signed [23:0] out_push_y;
  logic out_moving;

  potential_field_motion_step i_dut (.*);

  longint gain, radius, width_u, height_u;
  longint drone_x, drone_y;
  bit     started;
  int     obs_x [NUM_OBSTACLES];
  int     obs_y [NUM_OBSTACLES];

  motion_t pending_motion[$];
  int  errors;
  int  cycles;
  int  results_seen;
  int  ticks_sent;
  bit  calm_recv;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d, %0d results outstanding", cycles, pending_motion.size());
      $display("tb_potential_field_motion_step: errors");
      $finish;
    end
  end

  function automatic longint root_floor(longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r = r + 1;
    return r;
  endfunction

  function automatic longint isqrt(longint n);
    longint r, lo, hi, mid;
    lo = 0;
    hi = 1 << 20;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic longint repel_mag(longint d, longint rho);
    longint full, diff, sq;
    full = longint'(1) << (2 * FRAC_BITS);
    diff = full / d - full / rho;
    sq = (diff * diff) >>> FRAC_BITS;
    return (gain * sq) >>> FRAC_BITS;
  endfunction

  function automatic longint heading(longint c);
    if (c * 10 > ONE) return ONE;
    if (c * 10 < -ONE) return -ONE;
    return 0;
  endfunction

  function automatic longint step_of(longint dir, longint push);
    longint num;
    num = 10 * dir + push + 50;
    if (num >= 0) return num / 100;
    return -((-num + 99) / 100);
  endfunction

  function automatic longint span(longint v);
    if (v < 2) return 2;
    if (v > (1 << COORD_BITS) - 1) return (1 << COORD_BITS) - 1;
    return v;
  endfunction

  function automatic longint floor_d(longint d);
    return d < DMIN ? DMIN : d;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint clamp_axis(longint p, longint dim);
    if (p < ONE) p = ONE;
    if (p > (dim - 1) * ONE) p = (dim - 1) * ONE;
    return p;
  endfunction

  // advance the drone model; returns 1 with the result when a tick
  function automatic bit advance_drone(input logic [1:0] kind, input logic signed [15:0] cx,
                                       input logic signed [15:0] cy, input logic [3:0] slot,
                                       input logic [9:0] ox, input logic [9:0] oy,
                                       output motion_t res);
    longint w, h, d, sx, sy, px, py, dx, dy, ax, ay, m, hx, hy;
    res = '0;
    px = 0;
    py = 0;
    if (kind == REQ_WRITE) begin
      obs_x[slot] = ox;
      obs_y[slot] = oy;
      return 0;
    end
    if (kind == REQ_CLEAR) begin
      foreach (obs_x[i]) begin
        obs_x[i] = 0;
        obs_y[i] = 0;
      end
      return 0;
    end
    if (kind != REQ_TICK) return 0;
    hx = heading(longint'(cx));
    hy = heading(longint'(cy));
    if (hx != 0 || hy != 0) started = 1;
    if (started) begin
      w = span(width_u);
      h = span(height_u);
      sx = 0;
      sy = 0;
      d = floor_d(drone_x);
      if (d < radius) sx += repel_mag(d, radius);
      d = floor_d(w * ONE - drone_x);
      if (d < radius) sx -= repel_mag(d, radius);
      d = floor_d(drone_y);
      if (d < radius) sy += repel_mag(d, radius);
      d = floor_d(h * ONE - drone_y);
      if (d < radius) sy -= repel_mag(d, radius);
      for (int i = 0; i < NUM_OBSTACLES; i++) begin
        if (obs_x[i] == 0) continue;
        dx = drone_x - longint'(obs_x[i]) * ONE;
        dy = drone_y - longint'(obs_y[i]) * ONE;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax >= (1 << 18) || ay >= (1 << 18)) continue;
        d = floor_d(isqrt(ax * ax + ay * ay));
        if (d < radius) begin
          m = repel_mag(d, radius);
          sx += dx < 0 ? -((m * ax) / d) : (m * ax) / d;
          sy += dy < 0 ? -((m * ay) / d) : (m * ay) / d;
        end
      end
      px = sat24(sx);
      py = sat24(sy);
      if (hx != 0 && hy != 0) begin
        hx = hx > 0 ? DIAG : -DIAG;
        hy = hy > 0 ? DIAG : -DIAG;
      end
      drone_x = clamp_axis(drone_x + step_of(hx, px), w);
      drone_y = clamp_axis(drone_y + step_of(hy, py), h);
    end
    res.pos_x = drone_x[17:0];
    res.pos_y = drone_y[17:0];
    res.push_x = px[23:0];
    res.push_y = py[23:0];
    res.moving = started;
    return 1;
  endfunction

  always @(posedge clk) begin
    motion_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_position_x_out, out_position_y_out, out_push_x, out_push_y, out_moving};
      results_seen <= results_seen + 1;
      if (pending_motion.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors <= errors + 1;
      end else begin
        want = pending_motion.pop_front();
        if (got.pos_x !== want.pos_x) begin
          $display("%0t: position x expected %0d got %0d", $time, want.pos_x, got.pos_x);
          errors <= errors + 1;
        end
        if (got.pos_y !== want.pos_y) begin
          $display("%0t: position y expected %0d got %0d", $time, want.pos_y, got.pos_y);
          errors <= errors + 1;
        end
        if (got.push_x !== want.push_x) begin
          $display("%0t: push x expected %0d got %0d", $time, want.push_x, got.push_x);
          errors <= errors + 1;
        end
        if (got.push_y !== want.push_y) begin
          $display("%0t: push y expected %0d got %0d", $time, want.push_y, got.push_y);
          errors <= errors + 1;
        end
        if (got.moving !== want.moving) begin
          $display("%0t: moving expected %0b got %0b", $time, want.moving, got.moving);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm_recv ? 1'b1 : ($urandom_range(0, 99) >= 26);
  end

  task automatic send_request(input row_t r, input bit calm);
    motion_t res;
    bit has;
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_command_x <= r.cmd_x;
    in_command_y <= r.cmd_y;
    in_entry_index <= r.slot;
    in_entry_x <= r.ox;
    in_entry_y <= r.oy;
    do @(posedge clk); while (!in_ready);
    has = advance_drone(r.kind, r.cmd_x, r.cmd_y, r.slot, r.ox, r.oy, res);
    if (has) begin
      ticks_sent++;
      if (r.typed && res !== r.want) begin
        $display("%0t: typed row expected %p model %p", $time, r.want, res);
        errors++;
      end
      pending_motion.push_back(res);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input longint v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[17:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GAIN:   gain = v & 16'hFFFF;
      REG_RADIUS: radius = v & 18'h3FFFF;
      REG_WIDTH:  width_u = v & 10'h3FF;
      default:    height_u = v & 10'h3FF;
    endcase
  endtask

  function automatic row_t mk(logic [1:0] k, int cx, int cy, int s, int ox, int oy);
    row_t r;
    r.kind = k;
    r.cmd_x = cx[15:0];
    r.cmd_y = cy[15:0];
    r.slot = s[3:0];
    r.ox = ox[9:0];
    r.oy = oy[9:0];
    r.typed = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t rand_row();
    int sel;
    row_t r;
    sel = $urandom_range(0, 99);
    r = mk(REQ_TICK, 0, 0, $urandom_range(0, 15), 0, 0);
    if (sel < 70) begin
      r.cmd_x = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100) - 50);
      r.cmd_y = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100) - 50);
    end else if (sel < 92) begin
      r.kind = REQ_WRITE;
      r.ox = 10'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 90));
      r.oy = 10'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 50));
    end else if (sel < 96) begin
      r.kind = REQ_CLEAR;
    end else begin
      r.kind = REQ_UNKNOWN;
      r.cmd_x = 16'($urandom);
    end
    return r;
  endfunction

  initial begin
    row_t directed[$];
    row_t r;
    motion_t w0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_req_type = REQ_TICK;
    in_command_x = '0;
    in_command_y = '0;
    in_entry_index = '0;
    in_entry_x = '0;
    in_entry_y = '0;
    errors = 0;
    cycles = 0;
    results_seen = 0;
    ticks_sent = 0;
    calm_recv = 0;
    gain = 256;
    radius = 1280;
    width_u = 80;
    height_u = 40;
    drone_x = 40 * ONE;
    drone_y = 20 * ONE;
    started = 0;
    foreach (obs_x[i]) begin
      obs_x[i] = 0;
      obs_y[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle tick after reset: centre, no push, not moving
    r = mk(REQ_TICK, 25, -25, 0, 0, 0);
    r.typed = 1;
    w0 = '0;
    w0.pos_x = 40 * ONE;
    w0.pos_y = 20 * ONE;
    r.want = w0;
    directed.push_back(r);
    directed.push_back(mk(REQ_UNKNOWN, 32767, 32767, 0, 5, 5));
    directed.push_back(mk(REQ_WRITE, 0, 0, 0, 41, 20));
    directed.push_back(mk(REQ_WRITE, 0, 0, 1, 40, 20));
    directed.push_back(mk(REQ_WRITE, 0, 0, 15, 1023, 1023));
    directed.push_back(mk(REQ_WRITE, 0, 0, 2, 0, 7));
    directed.push_back(mk(REQ_TICK, 26, 0, 0, 0, 0));
    directed.push_back(mk(REQ_TICK, -32768, 32767, 0, 0, 0));
    directed.push_back(mk(REQ_TICK, 32767, -32768, 0, 0, 0));
    directed.push_back(mk(REQ_TICK, 0, -26, 0, 0, 0));
    directed.push_back(mk(REQ_TICK, 0, 0, 0, 0, 0));
    directed.push_back(mk(REQ_WRITE, 0, 0, 7, 1, 1));
    directed.push_back(mk(REQ_TICK, -300, -300, 0, 0, 0));
    directed.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0));
    directed.push_back(mk(REQ_TICK, 25, 25, 0, 0, 0));
    foreach (directed[i]) send_request(directed[i], 0);
    drain_results();

    // extremes of the registers, including tiny radius and degenerate world
    set_reg(REG_GAIN, 65535);
    set_reg(REG_RADIUS, 26);
    set_reg(REG_WIDTH, 0);
    set_reg(REG_HEIGHT, 1023);
    for (int i = 0; i < 6; i++) send_request(mk(REQ_TICK, -300, 300, 0, 0, 0), 0);
    drain_results();
    set_reg(REG_RADIUS, 262143);
    set_reg(REG_WIDTH, 1023);
    set_reg(REG_HEIGHT, 2);
    send_request(mk(REQ_WRITE, 0, 0, 3, 512, 1), 0);
    for (int i = 0; i < 6; i++) send_request(mk(REQ_TICK, 300, 0, 0, 0, 0), 0);
    drain_results();
    set_reg(REG_GAIN, 0);
    set_reg(REG_RADIUS, 27);
    send_request(mk(REQ_TICK, 0, 0, 0, 0, 0), 0);
    drain_results();

    // random phases over several settings; one phase fully calm
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(REG_GAIN, ph == 5 ? 65535 : $urandom_range(0, 2048));
      set_reg(REG_RADIUS, ph == 4 ? 262143 : $urandom_range(26, 4000));
      set_reg(REG_WIDTH, ph == 3 ? 1023 : $urandom_range(2, 120));
      set_reg(REG_HEIGHT, ph == 3 ? 1023 : $urandom_range(2, 120));
      calm_recv = (ph == 2);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        send_request(rand_row(), ph == 2);
        if (i == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_motion.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end

    $display("covered %0d ticks and %0d results over directed and six random phases",
             ticks_sent, results_seen);
    if (errors == 0) $display("tb_potential_field_motion_step: clean");
    else $display("tb_potential_field_motion_step: errors");
    $finish;
  end

endmodule
